FILE: hdl/abtf_pkg.sv
// ----------------------------------------------------------------------------
// abtf_pkg: shared definitions for the boundary tag allocator
// Field widths, heap constants, action and status codes, ALU controls and
// sequencer states.
// ----------------------------------------------------------------------------
package abtf_pkg;

	localparam int unsigned HEAP_BYTES_DEF  = 4096;
	localparam int unsigned TAG_BYTES       = 16;
	localparam int unsigned MIN_BLOCK_BYTES = 32;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned REQ_W    = 13;
	localparam int unsigned ADDR_W   = 12;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_FREE    = 2'd1,
		ACT_REALLOC = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 2'd0,
		ST_IGNORED   = 2'd1,
		ST_NO_MEMORY = 2'd2,
		ST_FREED     = 2'd3
	} status_t;

	// constant operand of the shared adder
	typedef enum logic [1:0] {
		K_ZERO,
		K_TAG,
		K_2TAG
	} kconst_t;

	typedef struct packed {
		logic    sub_b;
		logic    sub_k;
		kconst_t k_sel;
	} alu_op_t;

	typedef enum logic [4:0] {
		S_INIT0,
		S_INIT1,
		S_IDLE,
		S_F0,
		S_F1,
		S_F2,
		S_F3,
		S_F4,
		S_F5,
		S_F6,
		S_FEND,
		S_MK_H,
		S_MK_F,
		S_A0,
		S_A1,
		S_S0,
		S_S1,
		S_G0,
		S_G1,
		S_AD
	} state_t;

endpackage

FILE: hdl/abtf_tag_ram.sv
// ----------------------------------------------------------------------------
// abtf_tag_ram: boundary tag storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module abtf_tag_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned DW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/abtf_alu.sv
// ----------------------------------------------------------------------------
// abtf_alu: shared offset adder
// Computes a +/- b +/- constant; the top bit of the result flags a negative.
// ----------------------------------------------------------------------------
module abtf_alu
	import abtf_pkg::*;
#(
	parameter int unsigned WW = 15
) (
	input  logic [WW-1:0] a,
	input  logic [WW-1:0] b,
	input  alu_op_t       op,
	output logic [WW:0]   res
);

	logic [WW:0] ax;
	logic [WW:0] bx;
	logic [WW:0] kx;
	logic [WW:0] bt;
	logic [WW:0] kt;

	always_comb begin
		ax = {1'b0, a};
		bx = {1'b0, b};
		unique case (op.k_sel)
			K_ZERO:  kx = '0;
			K_TAG:   kx = (WW+1)'(TAG_BYTES);
			K_2TAG:  kx = (WW+1)'(2 * TAG_BYTES);
			default: kx = '0;
		endcase
		bt  = op.sub_b ? (~bx + 1'b1) : bx;
		kt  = op.sub_k ? (~kx + 1'b1) : kx;
		res = ax + bt + kt;
	end

endmodule

FILE: hdl/abtf_ctrl.sv
// ----------------------------------------------------------------------------
// abtf_ctrl: allocator sequencer
// Walks the tag chain, merges on free, splits or grows on allocate, one
// adder operation and at most one tag access per step.
// ----------------------------------------------------------------------------
module abtf_ctrl
	import abtf_pkg::*;
#(
	parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [ACTION_W-1:0]                   action,
	input  logic [REQ_W-1:0]                      request_size,
	input  logic                                  has_address,
	input  logic [ADDR_W-1:0]                     address_in,
	output logic                                  busy,
	output logic                                  done,
	output logic [STATUS_W-1:0]                   status,
	output logic [ADDR_W-1:0]                     address_out,
	output logic                                  mem_we,
	output logic [$clog2(HEAP_BYTES)-1:0]         mem_waddr,
	output logic [$clog2(HEAP_BYTES)+1:0]         mem_wdata,
	output logic [$clog2(HEAP_BYTES)-1:0]         mem_raddr,
	input  logic [$clog2(HEAP_BYTES)+1:0]         mem_rdata,
	output logic [(($clog2(HEAP_BYTES) > REQ_W) ? $clog2(HEAP_BYTES) : REQ_W)+1:0] alu_a,
	output logic [(($clog2(HEAP_BYTES) > REQ_W) ? $clog2(HEAP_BYTES) : REQ_W)+1:0] alu_b,
	output alu_op_t                               alu_op,
	input  logic [(($clog2(HEAP_BYTES) > REQ_W) ? $clog2(HEAP_BYTES) : REQ_W)+2:0] alu_res
);

	localparam int unsigned AW         = $clog2(HEAP_BYTES);
	localparam int unsigned SW         = AW + 1;
	localparam int unsigned BW         = AW + 1;
	localparam int unsigned WW         = ((AW > REQ_W) ? AW : REQ_W) + 2;
	localparam int unsigned WALK_LIMIT = HEAP_BYTES / (2 * TAG_BYTES) + 4;
	localparam int unsigned CW         = $clog2(WALK_LIMIT);

	state_t          state_q, state_d;
	state_t          ret_q, ret_d;
	logic            done_q, done_d;
	logic            pend_q, pend_d;
	logic [BW-1:0]   brk_q, brk_d;
	logic [BW-1:0]   tail_q, tail_d;

	status_t         status_q, status_d;
	logic [ADDR_W-1:0] aout_q, aout_d;
	logic [REQ_W-1:0] need_q, need_d;
	logic [WW-1:0]   addr_q, addr_d;
	logic [WW-1:0]   cur_q, cur_d;
	logic [SW-1:0]   csize_q, csize_d;
	logic [WW-1:0]   nxt_q, nxt_d;
	logic [WW-1:0]   prv_q, prv_d;
	logic [SW-1:0]   psize_q, psize_d;
	logic            pfree_q, pfree_d;
	logic [WW-1:0]   sum_q, sum_d;
	logic [WW-1:0]   mb_q, mb_d;
	logic [SW-1:0]   ms_q, ms_d;
	logic            mf_q, mf_d;
	logic [WW-1:0]   mfoot_q, mfoot_d;
	logic [WW-1:0]   blk_q, blk_d;
	logic [SW-1:0]   old_q, old_d;
	logic [SW-1:0]   rem_q, rem_d;
	logic [WW-1:0]   newbrk_q, newbrk_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            rd_oob_q;

	logic [WW-1:0]   rd_addr;
	logic            wr_en;
	logic [WW-1:0]   wr_addr;
	logic [SW-1:0]   wr_size;
	logic            wr_free;

	logic [SW-1:0]   tag_sz;
	logic            tag_fr;
	logic [WW-1:0]   tag_sz_w;
	logic [WW-1:0]   need_w;
	logic [WW-1:0]   tail_w;
	logic [WW-1:0]   res_w;
	logic            res_neg;
	logic [WW-1:0]   next_w;

	assign tag_sz   = rd_oob_q ? '0 : mem_rdata[SW-1:0];
	assign tag_fr   = rd_oob_q ? 1'b0 : mem_rdata[SW];
	assign tag_sz_w = {{(WW-SW){1'b0}}, tag_sz};
	assign need_w   = {{(WW-REQ_W){1'b0}}, need_q};
	assign tail_w   = {{(WW-BW){1'b0}}, tail_q};
	assign res_w    = alu_res[WW-1:0];
	assign res_neg  = alu_res[WW];
	assign next_w   = (cur_q == '0) ? WW'(TAG_BYTES) : res_w;

	assign mem_we    = wr_en && (wr_addr < WW'(HEAP_BYTES));
	assign mem_waddr = wr_addr[AW-1:0];
	assign mem_wdata = {wr_free, wr_size};
	assign mem_raddr = rd_addr[AW-1:0];

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign address_out = aout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
			ret_q   <= S_IDLE;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
			brk_q   <= BW'(2 * TAG_BYTES);
			tail_q  <= BW'(TAG_BYTES);
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			done_q  <= done_d;
			pend_q  <= pend_d;
			brk_q   <= brk_d;
			tail_q  <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		aout_q   <= aout_d;
		need_q   <= need_d;
		addr_q   <= addr_d;
		cur_q    <= cur_d;
		csize_q  <= csize_d;
		nxt_q    <= nxt_d;
		prv_q    <= prv_d;
		psize_q  <= psize_d;
		pfree_q  <= pfree_d;
		sum_q    <= sum_d;
		mb_q     <= mb_d;
		ms_q     <= ms_d;
		mf_q     <= mf_d;
		mfoot_q  <= mfoot_d;
		blk_q    <= blk_d;
		old_q    <= old_d;
		rem_q    <= rem_d;
		newbrk_q <= newbrk_d;
		cnt_q    <= cnt_d;
		rd_oob_q <= (rd_addr >= WW'(HEAP_BYTES));
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		done_d   = 1'b0;
		pend_d   = pend_q;
		brk_d    = brk_q;
		tail_d   = tail_q;
		status_d = status_q;
		aout_d   = aout_q;
		need_d   = need_q;
		addr_d   = addr_q;
		cur_d    = cur_q;
		csize_d  = csize_q;
		nxt_d    = nxt_q;
		prv_d    = prv_q;
		psize_d  = psize_q;
		pfree_d  = pfree_q;
		sum_d    = sum_q;
		mb_d     = mb_q;
		ms_d     = ms_q;
		mf_d     = mf_q;
		mfoot_d  = mfoot_q;
		blk_d    = blk_q;
		old_d    = old_q;
		rem_d    = rem_q;
		newbrk_d = newbrk_q;
		cnt_d    = cnt_q;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_size  = '0;
		wr_free  = 1'b0;
		alu_a    = '0;
		alu_b    = '0;
		alu_op   = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: K_ZERO};

		unique case (state_q)
			S_INIT0: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				state_d = S_INIT1;
			end
			S_INIT1: begin
				wr_en   = 1'b1;
				wr_addr = WW'(TAG_BYTES);
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					addr_d = {{(WW-ADDR_W){1'b0}}, address_in};
					need_d = (request_size < REQ_W'(MIN_BLOCK_BYTES)) ?
						REQ_W'(MIN_BLOCK_BYTES) : request_size;
					aout_d = '0;
					unique case (action_t'(action))
						ACT_FREE: begin
							pend_d = 1'b0;
							if (has_address) begin
								state_d = S_F0;
							end else begin
								done_d   = 1'b1;
								status_d = ST_FREED;
							end
						end
						ACT_ALLOC, ACT_REALLOC: begin
							if (request_size == '0) begin
								done_d   = 1'b1;
								status_d = ST_IGNORED;
							end else begin
								pend_d  = 1'b1;
								state_d = (action_t'(action) == ACT_REALLOC && has_address) ?
									S_F0 : S_A0;
							end
						end
						default: begin
							done_d   = 1'b1;
							status_d = ST_IGNORED;
						end
					endcase
				end
			end
			// free: locate block, its neighbors, then merge
			S_F0: begin
				alu_a  = addr_q;
				alu_op = '{sub_b: 1'b0, sub_k: 1'b1, k_sel: K_TAG};
				if (addr_q < WW'(2 * TAG_BYTES)) begin
					state_d = S_FEND;
				end else begin
					cur_d   = res_w;
					rd_addr = res_w;
					state_d = S_F1;
				end
			end
			S_F1: begin
				alu_a   = cur_q;
				alu_b   = tag_sz_w;
				alu_op  = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: K_2TAG};
				csize_d = tag_sz;
				nxt_d   = res_w;
				state_d = (res_w > tail_w) ? S_FEND : S_F2;
			end
			S_F2: begin
				alu_a   = cur_q;
				alu_op  = '{sub_b: 1'b0, sub_k: 1'b1, k_sel: K_TAG};
				rd_addr = res_w;
				state_d = S_F3;
			end
			S_F3: begin
				alu_a   = cur_q;
				alu_b   = tag_sz_w;
				alu_op  = '{sub_b: 1'b1, sub_k: 1'b1, k_sel: K_2TAG};
				psize_d = tag_sz;
				if (tag_sz != '0 && !res_neg) begin
					prv_d   = res_w;
					rd_addr = res_w;
					state_d = S_F4;
				end else begin
					pfree_d = 1'b0;
					rd_addr = nxt_q;
					state_d = S_F5;
				end
			end
			S_F4: begin
				pfree_d = tag_fr;
				psize_d = tag_sz;
				rd_addr = nxt_q;
				state_d = S_F5;
			end
			S_F5: begin
				alu_a   = {{(WW-SW){1'b0}}, csize_q};
				alu_b   = tag_fr ? tag_sz_w : '0;
				alu_op  = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: (tag_fr ? K_2TAG : K_ZERO)};
				sum_d   = res_w;
				state_d = S_F6;
			end
			S_F6: begin
				alu_a   = sum_q;
				alu_b   = pfree_q ? {{(WW-SW){1'b0}}, psize_q} : '0;
				alu_op  = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: (pfree_q ? K_2TAG : K_ZERO)};
				mb_d    = pfree_q ? prv_q : cur_q;
				ms_d    = res_w[SW-1:0];
				mf_d    = 1'b1;
				ret_d   = S_FEND;
				state_d = S_MK_H;
			end
			S_FEND: begin
				if (pend_q) begin
					state_d = S_A0;
				end else begin
					done_d   = 1'b1;
					status_d = ST_FREED;
					aout_d   = '0;
					state_d  = S_IDLE;
				end
			end
			// write header and footer of one block
			S_MK_H: begin
				wr_en   = 1'b1;
				wr_addr = mb_q;
				wr_size = ms_q;
				wr_free = mf_q;
				alu_a   = mb_q;
				alu_b   = {{(WW-SW){1'b0}}, ms_q};
				alu_op  = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: K_TAG};
				mfoot_d = res_w;
				state_d = S_MK_F;
			end
			S_MK_F: begin
				wr_en   = 1'b1;
				wr_addr = mfoot_q;
				wr_size = ms_q;
				wr_free = mf_q;
				state_d = ret_q;
			end
			// allocate: first-fit walk from the head fence
			S_A0: begin
				cur_d   = '0;
				cnt_d   = '0;
				rd_addr = '0;
				state_d = S_A1;
			end
			S_A1: begin
				alu_a  = cur_q;
				alu_b  = tag_sz_w;
				alu_op = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: K_2TAG};
				priority if (tag_fr && tag_sz_w >= need_w) begin
					blk_d   = cur_q;
					old_d   = tag_sz;
					state_d = S_S0;
				end else if (cur_q == tail_w) begin
					state_d = S_G0;
				end else if (next_w > tail_w) begin
					state_d = S_G0;
				end else if (cnt_q == CW'(WALK_LIMIT - 1)) begin
					state_d = S_G0;
				end else begin
					cur_d   = next_w;
					cnt_d   = cnt_q + 1'b1;
					rd_addr = next_w;
				end
			end
			S_S0: begin
				alu_a  = {{(WW-SW){1'b0}}, old_q};
				alu_b  = need_w;
				alu_op = '{sub_b: 1'b1, sub_k: 1'b1, k_sel: K_2TAG};
				mb_d   = blk_q;
				mf_d   = 1'b0;
				if (!res_neg && res_w > WW'(MIN_BLOCK_BYTES)) begin
					ms_d  = need_w[SW-1:0];
					rem_d = res_w[SW-1:0];
					ret_d = S_S1;
				end else begin
					ms_d  = old_q;
					ret_d = S_AD;
				end
				state_d = S_MK_H;
			end
			S_S1: begin
				alu_a   = blk_q;
				alu_b   = need_w;
				alu_op  = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: K_2TAG};
				mb_d    = res_w;
				ms_d    = rem_q;
				mf_d    = 1'b1;
				ret_d   = S_AD;
				state_d = S_MK_H;
			end
			// grow the heap past the tail fence
			S_G0: begin
				alu_a    = {{(WW-BW){1'b0}}, brk_q};
				alu_b    = need_w;
				alu_op   = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: K_2TAG};
				newbrk_d = res_w;
				if (res_w > WW'(HEAP_BYTES)) begin
					done_d   = 1'b1;
					status_d = ST_NO_MEMORY;
					aout_d   = '0;
					state_d  = S_IDLE;
				end else begin
					mb_d    = tail_w;
					blk_d   = tail_w;
					ms_d    = need_w[SW-1:0];
					mf_d    = 1'b0;
					ret_d   = S_G1;
					state_d = S_MK_H;
				end
			end
			S_G1: begin
				alu_a   = newbrk_q;
				alu_op  = '{sub_b: 1'b0, sub_k: 1'b1, k_sel: K_TAG};
				wr_en   = 1'b1;
				wr_addr = res_w;
				brk_d   = newbrk_q[BW-1:0];
				tail_d  = res_w[BW-1:0];
				state_d = S_AD;
			end
			S_AD: begin
				alu_a    = blk_q;
				alu_op   = '{sub_b: 1'b0, sub_k: 1'b0, k_sel: K_TAG};
				done_d   = 1'b1;
				status_d = ST_ALLOCATED;
				aout_d   = res_w[ADDR_W-1:0];
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_done_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe outside idle");

	a_tail_tracks_break: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q == tail_q + BW'(TAG_BYTES))
		else $error("tail fence out of step with heap break");

	a_break_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= BW'(HEAP_BYTES))
		else $error("heap break beyond heap");

	a_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q != S_IDLE)
		else $error("tag write while idle");

	a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_ALLOCATED) |-> aout_q == '0)
		else $error("nonzero address without allocation");

endmodule

FILE: hdl/boundary_tag_first_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_top: first-fit boundary tag heap allocator
// Allocate, free and reallocate over a byte-offset heap with header and
// footer tags, merging free neighbors and growing the heap on demand.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result
// appears on status and address_out for a single cycle with done high, and
// must be captured then since there is no back-pressure. After reset the
// block writes the head and tail fences, in S_INIT0 and S_INIT1, before it
// takes its first request. All work runs through one adder and one tag
// memory. An unknown, zero-size or null free request is answered straight
// from idle; an allocate walks the blocks first-fit, visiting at most
// HEAP_BYTES/(2*TAG_BYTES)+4 of them, and grows the heap if none fits; a
// reallocate with an address frees the block before it allocates.
module boundary_tag_first_fit_allocator_top
	import abtf_pkg::*;
#(
	parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ACTION_W-1:0] action,
	input  logic [REQ_W-1:0]    request_size,
	input  logic                has_address,
	input  logic [ADDR_W-1:0]   address_in,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [ADDR_W-1:0]   address_out
);

	localparam int unsigned AW = $clog2(HEAP_BYTES);
	localparam int unsigned TW = AW + 2;
	localparam int unsigned WW = ((AW > REQ_W) ? AW : REQ_W) + 2;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [TW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [TW-1:0] mem_rdata;
	logic [WW-1:0] alu_a;
	logic [WW-1:0] alu_b;
	alu_op_t       alu_op;
	logic [WW:0]   alu_res;

	abtf_ctrl #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.request_size(request_size),
		.has_address (has_address),
		.address_in  (address_in),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.address_out (address_out),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.alu_a       (alu_a),
		.alu_b       (alu_b),
		.alu_op      (alu_op),
		.alu_res     (alu_res)
	);

	abtf_alu #(
		.WW(WW)
	) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.res(alu_res)
	);

	abtf_tag_ram #(
		.DEPTH(HEAP_BYTES),
		.AW   (AW),
		.DW   (TW)
	) u_tag_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
